// File: rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared widths, types and constants for the windowed sample statistics block.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int SAMPLE_W = 15;
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 32;
    localparam int SQSUM_W  = 44;
    localparam int VAR_W    = 28;

    // |sum| < 2^(SAMPLE_W-1) * 2^COUNT_W
    localparam int MAG_W    = SAMPLE_W + COUNT_W - 1;
    localparam int PROD_W   = SQSUM_W + COUNT_W;
    localparam int SQR_W    = 2 * MAG_W;
    localparam int NUM_W    = (PROD_W > SQR_W) ? PROD_W : SQR_W;
    localparam int DEN_W    = 2 * COUNT_W;
    localparam int ACC_CYC  = (SQSUM_W > SUM_W) ? SQSUM_W : SUM_W;
    localparam int SEQ_MAX  = (NUM_W > ACC_CYC) ? NUM_W : ACC_CYC;
    localparam int SEQ_W    = $clog2(SEQ_MAX + 1);
    localparam int DIV_CW   = $clog2(NUM_W + 1);

    localparam logic [COUNT_W-1:0] WIN_LEN_RESET = COUNT_W'(360);
    localparam logic [COUNT_W-1:0] WIN_LEN_MIN   = COUNT_W'(2);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ACC   = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_VLOAD = 8'b0001_0000,
        S_VDIV  = 8'b0010_0000,
        S_MLOAD = 8'b0100_0000,
        S_MDIV  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quotient;
    } t_div_sts;

endpackage

// File: rtl/wss_divider.sv
// ----------------------------------------------------------------------------
// wss_divider
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module wss_divider import wss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_sts o_sts
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_step;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_dvsr;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W+1:0]  w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvsr};
    assign w_ge    = ~w_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DEN_W bits hold it
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

// File: rtl/windowed_sample_statistics_top.sv
// ----------------------------------------------------------------------------
// windowed_sample_statistics_top
// Input: o_in_stall is high outside idle, so the next sample waits until the
//   bit-serial square-sum accumulator, SQSUM_W bits one per cycle, is done.
// Result: the sample that closes a window goes through the accumulate pass,
//   prep, a serial multiply pass, and two radix-2 divisions (variance, then
//   mean), each after a load state; the result then waits for a free output.
// Reset: synchronous, active low; window_len returns to 360, statistics clear.
// ----------------------------------------------------------------------------
module windowed_sample_statistics_top import wss_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_wr_en,
    input  logic [COUNT_W-1:0]         i_cfg_wr_data,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_mean_value,
    output logic signed [SAMPLE_W-1:0] o_high_mark,
    output logic signed [SAMPLE_W-1:0] o_low_mark,
    output logic [SAMPLE_W-1:0]        o_spread,
    output logic [VAR_W-1:0]           o_variance,
    output logic [SAMPLE_W-1:0]        o_max_step
);

    // ------------------------------------------------------------------
    // Control and statistics registers (reset)
    // ------------------------------------------------------------------
    t_state                       r_state,      n_state;
    logic [SEQ_W-1:0]             r_seq,        n_seq;
    logic [COUNT_W-1:0]           r_window_len;
    logic [COUNT_W-1:0]           r_count,      n_count;
    logic [SUM_W-1:0]             r_sum,        n_sum;
    logic [SQSUM_W-1:0]           r_sqsum,      n_sqsum;
    logic signed [SAMPLE_W-1:0]   r_lo,         n_lo;
    logic signed [SAMPLE_W-1:0]   r_hi,         n_hi;
    logic signed [SAMPLE_W-1:0]   r_prev,       n_prev;
    logic [SAMPLE_W-1:0]          r_step_max,   n_step_max;
    logic                         r_out_valid,  n_out_valid;

    // ------------------------------------------------------------------
    // Serial datapath registers (no reset, loaded before use)
    // ------------------------------------------------------------------
    // per-sample pass: sample shifter, square multiplier, serial carries
    logic [SAMPLE_W-1:0]          r_samp_sh,    n_samp_sh;
    logic [SAMPLE_W-1:0]          r_sq_mcand,   n_sq_mcand;
    logic [SAMPLE_W-1:0]          r_sq_mplier,  n_sq_mplier;
    logic [SAMPLE_W-1:0]          r_sq_acc,     n_sq_acc;
    logic                         r_cy_sq,      n_cy_sq;
    logic                         r_cy_sum,     n_cy_sum;
    // window-end pass: three serial-parallel multipliers and a serial subtract
    logic                         r_neg,        n_neg;
    logic [MAG_W-1:0]             r_msh,        n_msh;
    logic [COUNT_W-1:0]           r_pa,         n_pa;
    logic [MAG_W-1:0]             r_pb,         n_pb;
    logic [COUNT_W-1:0]           r_pc,         n_pc;
    logic [COUNT_W-1:0]           r_nm1,        n_nm1;
    logic [DEN_W-1:0]             r_den,        n_den;
    logic [NUM_W-1:0]             r_num,        n_num;
    logic                         r_brw,        n_brw;
    logic [VAR_W-1:0]             r_var,        n_var;
    // output item
    logic [SAMPLE_W-1:0]          r_o_mean,     n_o_mean;
    logic [SAMPLE_W-1:0]          r_o_max,      n_o_max;
    logic [SAMPLE_W-1:0]          r_o_min,      n_o_min;
    logic [SAMPLE_W-1:0]          r_o_spread,   n_o_spread;
    logic [VAR_W-1:0]             r_o_var,      n_o_var;
    logic [SAMPLE_W-1:0]          r_o_step,     n_o_step;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]   w_limit;
    logic [SAMPLE_W:0]    w_diff;
    logic [SAMPLE_W:0]    w_diff_neg;
    logic [SAMPLE_W-1:0]  w_dmag;
    logic [SAMPLE_W-1:0]  w_sneg;
    logic [SAMPLE_W-1:0]  w_smag;
    logic                 w_accept;

    logic [SAMPLE_W-1:0]  w_sq_add;
    logic [SAMPLE_W:0]    w_sq_t;
    logic                 w_sq_bit;
    logic                 w_sqsum_bit;
    logic                 w_sqsum_cy;
    logic                 w_sum_bit;
    logic                 w_sum_cy;

    logic [SUM_W-1:0]     w_sum_abs;
    logic [MAG_W-1:0]     w_mag;
    logic [COUNT_W:0]     w_pa_t;
    logic [MAG_W:0]       w_pb_t;
    logic [COUNT_W:0]     w_pc_t;
    logic                 w_num_bit;
    logic                 w_brw_n;

    logic [SAMPLE_W-1:0]  w_q_lo;
    logic [SAMPLE_W-1:0]  w_q_lo_neg;
    logic                 w_out_free;

    t_div_req             w_div_req;
    t_div_sts             w_div_sts;

    // A window_len below two acts as two.
    assign w_limit = (r_window_len < WIN_LEN_MIN) ? WIN_LEN_MIN : r_window_len;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Step between consecutive samples; the difference of two samples always
    // fits SAMPLE_W+1 bits and its magnitude fits SAMPLE_W bits.
    assign w_diff     = {i_sample[SAMPLE_W-1], i_sample} - {r_prev[SAMPLE_W-1], r_prev};
    assign w_diff_neg = ~w_diff + 1'b1;
    assign w_dmag     = w_diff[SAMPLE_W] ? w_diff_neg[SAMPLE_W-1:0] : w_diff[SAMPLE_W-1:0];

    // |sample|: the most negative code maps to 2^(SAMPLE_W-1), still SAMPLE_W bits.
    assign w_sneg = ~i_sample + 1'b1;
    assign w_smag = i_sample[SAMPLE_W-1] ? w_sneg : i_sample;

    // Per-sample pass. The shift-add multiplier retires one product bit per
    // cycle, LSB first, and that bit feeds the serial adder of the square sum.
    assign w_sq_add    = r_sq_mplier[0] ? r_sq_mcand : '0;
    assign w_sq_t      = {1'b0, r_sq_acc} + {1'b0, w_sq_add};
    assign w_sq_bit    = w_sq_t[0];
    assign w_sqsum_bit = r_sqsum[0] ^ w_sq_bit ^ r_cy_sq;
    assign w_sqsum_cy  = (r_sqsum[0] & w_sq_bit) | (r_cy_sq & (r_sqsum[0] ^ w_sq_bit));
    assign w_sum_bit   = r_sum[0] ^ r_samp_sh[0] ^ r_cy_sum;
    assign w_sum_cy    = (r_sum[0] & r_samp_sh[0]) | (r_cy_sum & (r_sum[0] ^ r_samp_sh[0]));

    // Window-end pass. After the prep cycle r_sum holds |sum|.
    assign w_sum_abs = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign w_mag     = r_sum[MAG_W-1:0];

    // n * sumsq, multiplier bits taken from the square-sum register
    assign w_pa_t = {1'b0, r_pa} + {1'b0, (r_sqsum[0] ? r_count : {COUNT_W{1'b0}})};
    // |sum| * |sum|
    assign w_pb_t = {1'b0, r_pb} + {1'b0, (r_msh[0] ? w_mag : {MAG_W{1'b0}})};
    // n * (n - 1)
    assign w_pc_t = {1'b0, r_pc} + {1'b0, (r_nm1[0] ? r_count : {COUNT_W{1'b0}})};

    // numerator = n*sumsq - sum^2, serial subtract; a final borrow clamps to 0
    assign w_num_bit = w_pa_t[0] ^ w_pb_t[0] ^ r_brw;
    assign w_brw_n   = (~w_pa_t[0] & w_pb_t[0]) | (~(w_pa_t[0] ^ w_pb_t[0]) & r_brw);

    // mean: low quotient bits, sign restored (truncation toward zero)
    assign w_q_lo     = w_div_sts.quotient[SAMPLE_W-1:0];
    assign w_q_lo_neg = ~w_q_lo + 1'b1;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Divider shared by the variance and the mean divisions.
    always_comb begin
        w_div_req.start    = (r_state == S_VLOAD) || (r_state == S_MLOAD);
        w_div_req.dividend = {{(NUM_W-MAG_W){1'b0}}, w_mag};
        w_div_req.divisor  = {{(DEN_W-COUNT_W){1'b0}}, r_count};
        if (r_state == S_VLOAD) begin
            w_div_req.dividend = r_brw ? {NUM_W{1'b0}} : r_num;
            w_div_req.divisor  = r_den;
        end
    end

    wss_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_sts   (w_div_sts)
    );

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_count     = r_count;
        n_sum       = r_sum;
        n_sqsum     = r_sqsum;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_prev      = r_prev;
        n_step_max  = r_step_max;
        n_out_valid = r_out_valid;

        n_samp_sh   = r_samp_sh;
        n_sq_mcand  = r_sq_mcand;
        n_sq_mplier = r_sq_mplier;
        n_sq_acc    = r_sq_acc;
        n_cy_sq     = r_cy_sq;
        n_cy_sum    = r_cy_sum;
        n_neg       = r_neg;
        n_msh       = r_msh;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_pc        = r_pc;
        n_nm1       = r_nm1;
        n_den       = r_den;
        n_num       = r_num;
        n_brw       = r_brw;
        n_var       = r_var;
        n_o_mean    = r_o_mean;
        n_o_max     = r_o_max;
        n_o_min     = r_o_min;
        n_o_spread  = r_o_spread;
        n_o_var     = r_o_var;
        n_o_step    = r_o_step;

        // output item leaves when the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // first sample of a window contributes no step
                    if (r_count != '0 && w_dmag > r_step_max) begin
                        n_step_max = w_dmag;
                    end
                    n_count = r_count + 1'b1;
                    if (i_sample < r_lo) begin
                        n_lo = i_sample;
                    end
                    if (i_sample > r_hi) begin
                        n_hi = i_sample;
                    end
                    n_prev      = i_sample;
                    n_samp_sh   = i_sample;
                    n_sq_mcand  = w_smag;
                    n_sq_mplier = w_smag;
                    n_sq_acc    = '0;
                    n_cy_sq     = 1'b0;
                    n_cy_sum    = 1'b0;
                    n_seq       = '0;
                    n_state     = S_ACC;
                end
            end

            S_ACC: begin
                n_sq_acc    = w_sq_t[SAMPLE_W:1];
                n_sq_mplier = {1'b0, r_sq_mplier[SAMPLE_W-1:1]};
                n_sqsum     = {w_sqsum_bit, r_sqsum[SQSUM_W-1:1]};
                n_cy_sq     = w_sqsum_cy;
                if (r_seq < SEQ_W'(SUM_W)) begin
                    n_sum     = {w_sum_bit, r_sum[SUM_W-1:1]};
                    n_cy_sum  = w_sum_cy;
                    n_samp_sh = {r_samp_sh[SAMPLE_W-1], r_samp_sh[SAMPLE_W-1:1]};
                end
                n_seq = r_seq + 1'b1;
                if (r_seq == SEQ_W'(ACC_CYC - 1)) begin
                    n_seq   = '0;
                    n_state = (r_count >= w_limit) ? S_PREP : S_IDLE;
                end
            end

            S_PREP: begin
                n_sum   = w_sum_abs;
                n_neg   = r_sum[SUM_W-1];
                n_msh   = w_sum_abs[MAG_W-1:0];
                n_pa    = '0;
                n_pb    = '0;
                n_pc    = '0;
                n_nm1   = r_count - 1'b1;
                n_brw   = 1'b0;
                n_seq   = '0;
                n_state = S_MUL;
            end

            S_MUL: begin
                n_pa    = w_pa_t[COUNT_W:1];
                n_sqsum = {1'b0, r_sqsum[SQSUM_W-1:1]};
                n_pb    = w_pb_t[MAG_W:1];
                n_msh   = {1'b0, r_msh[MAG_W-1:1]};
                n_pc    = w_pc_t[COUNT_W:1];
                n_nm1   = {1'b0, r_nm1[COUNT_W-1:1]};
                if (r_seq < SEQ_W'(DEN_W)) begin
                    n_den = {w_pc_t[0], r_den[DEN_W-1:1]};
                end
                n_num = {w_num_bit, r_num[NUM_W-1:1]};
                n_brw = w_brw_n;
                n_seq = r_seq + 1'b1;
                if (r_seq == SEQ_W'(NUM_W - 1)) begin
                    n_seq   = '0;
                    n_state = S_VLOAD;
                end
            end

            S_VLOAD: begin
                n_state = S_VDIV;
            end

            S_VDIV: begin
                if (w_div_sts.done) begin
                    // saturate the variance at its field width
                    n_var   = (|w_div_sts.quotient[NUM_W-1:VAR_W]) ? {VAR_W{1'b1}}
                                                                  : w_div_sts.quotient[VAR_W-1:0];
                    n_state = S_MLOAD;
                end
            end

            S_MLOAD: begin
                n_state = S_MDIV;
            end

            S_MDIV: begin
                // wait here while a previous item still sits in the output
                // register; the quotient holds once the divider is done
                if ((w_div_sts.done || r_seq != '0) && w_out_free) begin
                    n_o_mean    = r_neg ? w_q_lo_neg : w_q_lo;
                    n_o_max     = r_hi;
                    n_o_min     = r_lo;
                    n_o_spread  = SAMPLE_W'(r_hi - r_lo);
                    n_o_var     = r_var;
                    n_o_step    = r_step_max;
                    n_out_valid = 1'b1;
                    // new window
                    n_count     = '0;
                    n_sum       = '0;
                    n_sqsum     = '0;
                    n_lo        = SAMPLE_MAX;
                    n_hi        = SAMPLE_MIN;
                    n_prev      = '0;
                    n_step_max  = '0;
                    n_seq       = '0;
                    n_state     = S_IDLE;
                end else if (w_div_sts.done) begin
                    // mean ready; r_seq marks it for the output register
                    n_seq = SEQ_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seq        <= '0;
            r_window_len <= WIN_LEN_RESET;
            r_count      <= '0;
            r_sum        <= '0;
            r_sqsum      <= '0;
            r_lo         <= SAMPLE_MAX;
            r_hi         <= SAMPLE_MIN;
            r_prev       <= '0;
            r_step_max   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seq       <= n_seq;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_sqsum     <= n_sqsum;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_prev      <= n_prev;
            r_step_max  <= n_step_max;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_window_len <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_samp_sh   <= n_samp_sh;
        r_sq_mcand  <= n_sq_mcand;
        r_sq_mplier <= n_sq_mplier;
        r_sq_acc    <= n_sq_acc;
        r_cy_sq     <= n_cy_sq;
        r_cy_sum    <= n_cy_sum;
        r_neg       <= n_neg;
        r_msh       <= n_msh;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
        r_pc        <= n_pc;
        r_nm1       <= n_nm1;
        r_den       <= n_den;
        r_num       <= n_num;
        r_brw       <= n_brw;
        r_var       <= n_var;
        r_o_mean    <= n_o_mean;
        r_o_max     <= n_o_max;
        r_o_min     <= n_o_min;
        r_o_spread  <= n_o_spread;
        r_o_var     <= n_o_var;
        r_o_step    <= n_o_step;
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_o_mean;
    assign o_high_mark  = r_o_max;
    assign o_low_mark   = r_o_min;
    assign o_spread     = r_o_spread;
    assign o_variance   = r_o_var;
    assign o_max_step   = r_o_step;

endmodule

// File: test/wss_checker.sv
// ----------------------------------------------------------------------------
// wss_checker
// Watches the config, sample and result channels of the windowed sample
// statistics block, keeps its own copy of the window state, predicts each
// window result and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module wss_checker import wss_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [COUNT_W-1:0]         i_cfg_wr_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] i_mean_value,
    input  logic signed [SAMPLE_W-1:0] i_high_mark,
    input  logic signed [SAMPLE_W-1:0] i_low_mark,
    input  logic [SAMPLE_W-1:0]        i_spread,
    input  logic [VAR_W-1:0]           i_variance,
    input  logic [SAMPLE_W-1:0]        i_max_step,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] VAR_CEIL = (64'd1 << VAR_W) - 64'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic signed [SAMPLE_W-1:0] high_mark;
        logic signed [SAMPLE_W-1:0] low_mark;
        logic [SAMPLE_W-1:0]        spread;
        logic [VAR_W-1:0]           variance;
        logic [SAMPLE_W-1:0]        max_step;
    } t_window_stats;

    t_window_stats      due_windows[$];
    logic [COUNT_W-1:0] win_len;
    logic [COUNT_W-1:0] held;
    longint             sum_acc;
    logic [SQSUM_W-1:0] sq_acc;
    longint             lo_seen;
    longint             hi_seen;
    longint             last_seen;
    longint             big_step;
    int                 mismatches = 0;

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic void restart_window();
        held      = '0;
        sum_acc   = 0;
        sq_acc    = '0;
        lo_seen   = longint'(SAMPLE_MAX);
        hi_seen   = longint'(SAMPLE_MIN);
        last_seen = 0;
        big_step  = 0;
    endfunction

    // Folds one sample into the window; returns 1 with the stats when it closes.
    function automatic bit take_sample(input logic signed [SAMPLE_W-1:0] s,
                                       output t_window_stats w);
        longint      v;
        logic [63:0] step;
        logic [63:0] lim;
        logic [63:0] n;
        logic [63:0] prod;
        logic [63:0] sq;
        logic [63:0] num;
        logic [63:0] var_q;
        v = longint'(s);
        w = '0;
        // no step across the first sample of a window
        if (held != '0) begin
            step = magnitude(v - last_seen);
            if (step > 64'(big_step))
                big_step = longint'(step);
        end
        held    = held + 1'b1;
        sum_acc = sum_acc + v;
        sq_acc  = sq_acc + SQSUM_W'(magnitude(v) * magnitude(v));
        if (v < lo_seen)
            lo_seen = v;
        if (v > hi_seen)
            hi_seen = v;
        last_seen = v;

        lim = (win_len < WIN_LEN_MIN) ? 64'(WIN_LEN_MIN) : 64'(win_len);
        if (64'(held) < lim)
            return 1'b0;

        n     = 64'(held);
        prod  = n * 64'(sq_acc);
        sq    = magnitude(sum_acc) * magnitude(sum_acc);
        num   = (prod >= sq) ? prod - sq : 64'd0;
        var_q = num / (n * (n - 64'd1));
        if (var_q > VAR_CEIL)
            var_q = VAR_CEIL;

        w.mean_value = SAMPLE_W'(sum_acc / longint'(n));
        w.high_mark  = SAMPLE_W'(hi_seen);
        w.low_mark   = SAMPLE_W'(lo_seen);
        w.spread     = SAMPLE_W'(hi_seen - lo_seen);
        w.variance   = VAR_W'(var_q);
        w.max_step   = SAMPLE_W'(big_step);
        restart_window();
        return 1'b1;
    endfunction

    function automatic int check_field(input string name,
                                       input logic signed [63:0] want,
                                       input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t ns  %s mismatch: expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_window_stats fresh;
        t_window_stats want;
        int            bad;
        if (!i_rst_n) begin
            win_len = WIN_LEN_RESET;
            restart_window();
            due_windows.delete();
        end else begin
            if (i_cfg_wr_en)
                win_len = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (due_windows.size() == 0) begin
                    $display("%0t ns  unexpected result: expected none, got mean %0d var %0d",
                             $time, i_mean_value, i_variance);
                    mismatches++;
                end else begin
                    want = due_windows.pop_front();
                    bad  = 0;
                    bad += check_field("mean_value", $signed(want.mean_value), i_mean_value);
                    bad += check_field("high_mark", $signed(want.high_mark), i_high_mark);
                    bad += check_field("low_mark", $signed(want.low_mark), i_low_mark);
                    bad += check_field("spread", want.spread, i_spread);
                    bad += check_field("variance", want.variance, i_variance);
                    bad += check_field("max_step", want.max_step, i_max_step);
                    mismatches += bad;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (take_sample(i_sample, fresh))
                    due_windows.push_back(fresh);
            end
        end
        o_errors  <= mismatches;
        o_pending <= due_windows.size();
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives temperature samples and window_len settings into the windowed
// sample statistics block under random sender gaps and receiver stalls;
// a checker beside the block predicts every window result and compares it.
// ----------------------------------------------------------------------------
module testbench;
    import wss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 4;
    // A closing sample runs the whole window-end pass; any other sample
    // keeps the block busy through the accumulate pass after it is taken.
    localparam int SETTLE_CYCLES = 260;
    // Worst honest quiet spell: long sender gap + latency + long stall.
    localparam int IDLE_LIMIT    = 5000;
    localparam int ITEM_TARGET   = 1350;

    typedef enum int {
        TEMP_SPAN,   // uniform over the sensor range
        TEMP_DRIFT,  // slow random walk, realistic readings
        TEMP_RAW,    // any 15-bit pattern, out of range included
        TEMP_EDGE,   // range limits and word limits
        TEMP_HOLD    // one constant reading
    } t_temp_style;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]         i_cfg_wr_data = '0;
    logic                       i_in_valid    = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample      = '0;
    logic                       i_out_stall   = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_mean_value;
    logic signed [SAMPLE_W-1:0] o_high_mark;
    logic signed [SAMPLE_W-1:0] o_low_mark;
    logic [SAMPLE_W-1:0]        o_spread;
    logic [VAR_W-1:0]           o_variance;
    logic [SAMPLE_W-1:0]        o_max_step;

    int failures;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int walk_temp   = 2000;
    bit tx_throttle = 1'b1;
    bit rx_throttle = 1'b0;

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    windowed_sample_statistics_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mean_value  (o_mean_value),
        .o_high_mark   (o_high_mark),
        .o_low_mark    (o_low_mark),
        .o_spread      (o_spread),
        .o_variance    (o_variance),
        .o_max_step    (o_max_step)
    );

    wss_checker stats_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_mean_value  (o_mean_value),
        .i_high_mark   (o_high_mark),
        .i_low_mark    (o_low_mark),
        .i_spread      (o_spread),
        .i_variance    (o_variance),
        .i_max_step    (o_max_step),
        .o_errors      (failures),
        .o_pending     (pending)
    );

    // Receiver pacing: runs of free and stalled cycles, mostly short, a few
    // long enough to back up a finished window behind the output.
    always @(posedge i_clk) begin : rx_pace
        int r;
        if (!rx_throttle) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else if (r < 93) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(20, 300);
            end
        end
    end

    // Progress watchdog: any accepted item, result or config write resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("%0t ns  no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Sender gap before the next item: mostly none or short, rarely long
    // enough to land in the middle of the end-of-window divisions.
    function automatic int pick_gap();
        int r;
        if (!tx_throttle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 300);
    endfunction

    // Offers one sample and returns at the edge where it is taken; valid
    // stays up so back-to-back items keep the channel busy.
    task automatic send_sample(input int value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= SAMPLE_W'(value);
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Holds the sender until every predicted window has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // window_len only changes once the block has gone quiet; a sample that
    // closes no window can still be in the accumulator, hence the settle.
    task automatic set_window(input int len);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= COUNT_W'(len);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic int next_temp(input t_temp_style style);
        int edges[8] = '{-4000, 12500, -16384, 16383, 0, -1, 1, -16383};
        case (style)
            TEMP_SPAN: begin
                return int'($urandom_range(0, 16500)) - 4000;
            end
            TEMP_DRIFT: begin
                walk_temp += int'($urandom_range(0, 400)) - 200;
                if (walk_temp > 12500)
                    walk_temp = 12500;
                if (walk_temp < -4000)
                    walk_temp = -4000;
                return walk_temp;
            end
            TEMP_RAW: begin
                return int'($urandom_range(0, 32767)) - 16384;
            end
            TEMP_EDGE: begin
                return edges[$urandom_range(0, 7)];
            end
            default: begin
                return walk_temp;
            end
        endcase
    endfunction

    initial begin : stimulus
        int          r;
        int          len;
        int          eff;
        int          count;
        t_temp_style style;

        repeat (2) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        rx_throttle <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // Reset length of 360: three samples leave a partial window.
        send_sample(12500);
        send_sample(-4000);
        send_sample(0);
        // Zero acts as two and is already below the held count, so the next
        // sample closes a window of four.
        set_window(0);
        send_sample(16383);
        // Word extremes: variance saturates at the top of its field.
        send_sample(-16384);
        send_sample(16383);
        // Largest step inside the sensor range.
        send_sample(12500);
        send_sample(-4000);
        // One also acts as two; negative mean truncates toward zero,
        // then a flat window with zero variance.
        set_window(1);
        send_sample(-1);
        send_sample(-2);
        send_sample(5);
        send_sample(5);
        // Mean of zero by truncation; the jump 1 -> 100 spans two windows
        // and must not count as a step.
        set_window(3);
        send_sample(7);
        send_sample(-7);
        send_sample(1);
        send_sample(100);
        send_sample(100);
        send_sample(100);
        // Longest window, then shortened to the held count.
        set_window(65535);
        send_sample(1);
        send_sample(2);
        set_window(2);
        send_sample(3);

        // --- random phases ---
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                len = $urandom_range(0, 1);
            else if (r < 60)
                len = $urandom_range(2, 6);
            else if (r < 85)
                len = $urandom_range(7, 24);
            else if (r < 95)
                len = $urandom_range(25, 100);
            else if (r < 98)
                len = 360;
            else
                len = 65535;
            eff = (len < 2) ? 2 : len;

            if (len == 65535)
                count = $urandom_range(1, 6);
            else if (eff > 100)
                count = eff;
            else
                count = eff * $urandom_range(1, 5);
            // Leave a partial window now and then; the next phase may cut it.
            if (len != 65535 && $urandom_range(0, 3) == 0)
                count += $urandom_range(1, eff - 1);
            // keep the total close to the target
            if (count > ITEM_TARGET - items_sent)
                count = ITEM_TARGET - items_sent;

            r = $urandom_range(0, 99);
            if (r < 35)
                style = TEMP_SPAN;
            else if (r < 70)
                style = TEMP_DRIFT;
            else if (r < 82)
                style = TEMP_RAW;
            else if (r < 92)
                style = TEMP_EDGE;
            else
                style = TEMP_HOLD;
            if (style == TEMP_HOLD)
                walk_temp = int'($urandom_range(0, 16500)) - 4000;

            set_window(len);
            // Some phases run with no idling on one side or both.
            tx_throttle  = ($urandom_range(0, 4) != 0);
            rx_throttle <= ($urandom_range(0, 4) != 0);
            repeat (count) send_sample(next_temp(style));
        end

        // --- wind down ---
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
